// File: hw/rtl/bfst_pkg.sv
// bfst_pkg: shared types and constants of the best-fit sorted table
`default_nettype none

package bfst_pkg;

  localparam int unsigned ValW  = 32;
  localparam int unsigned OccW  = 9;
  localparam int unsigned StatW = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_TAKE   = 1'b1
  } opcode_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOFIT = 2'd2
  } status_e;

  // request item
  typedef struct packed {
    opcode_e             opcode;
    logic [ValW-1:0]     value;
  } req_t;

  // response item
  typedef struct packed {
    status_e             status;
    logic [ValW-1:0]     taken_value;
    logic [OccW-1:0]     occupancy;
  } rsp_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                ins_en;
    logic                take_en;
    logic [ValW-1:0]     key;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/bfst_stream_if.sv
// bfst_stream_if: valid/ready channel carrying one item per handshake
`default_nettype none

interface bfst_stream_if #(
  parameter type item_t = logic
) ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/best_fit_sorted_table.sv
// best_fit_sorted_table: sorted value table with best-fit take, built as a cell chain
//
//  channel | dir | modport | payload
//  --------+-----+---------+------------------------------------------
//  in_i    | in  | sink    | opcode, value
//  out_o   | out | source  | status, taken_value, occupancy
//
// the chain compares and shifts all entries at the accept edge, then the
// taken value is gathered through a two-level OR tree into the output register;
// the input is held while an accepted item's result is pending and reopens as
// that result moves into the output register, not before.
// a result waiting in the output register still lets one more item in; that
// item's result then holds the input until the output register frees.
// reset clears the fill count and handshake state only; entries keep no reset.
`default_nettype none

module best_fit_sorted_table #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  bfst_stream_if.sink   in_i,
  bfst_stream_if.source out_o
);
  import bfst_pkg::*;

  localparam int unsigned CntW    = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned GrpSize = 16;
  localparam int unsigned NumGrp  = (TABLE_DEPTH + GrpSize - 1) / GrpSize;

  logic [CntW-1:0] count_q, count_d;
  logic            pend_q;
  status_e         pend_status_q, pend_status_d;
  logic [OccW-1:0] pend_occ_q;
  logic [ValW-1:0] grp_q [NumGrp];
  logic [ValW-1:0] grp_d [NumGrp];
  logic            out_valid_q;
  rsp_t            out_q;
  logic [ValW-1:0] taken_all;

  logic            accept;
  logic            full;
  req_t            req;
  cell_cmd_t       cmd;

  logic            le   [TABLE_DEPTH];
  logic [ValW-1:0] vals [TABLE_DEPTH];
  logic [ValW-1:0] taken_pad [NumGrp*GrpSize];

  // input handshake
  assign req         = in_i.data;
  assign in_i.ready  = !pend_q;
  assign accept      = in_i.valid && in_i.ready;
  assign full        = count_q == CntW'(TABLE_DEPTH);

  // command to the chain
  assign cmd.ins_en  = accept && (req.opcode == OP_INSERT) && !full;
  assign cmd.take_en = accept && (req.opcode == OP_TAKE) && le[0];
  assign cmd.key     = req.value;

  // chain of cells
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic            le_left;
    logic            le_right;
    logic [ValW-1:0] val_left;
    logic [ValW-1:0] val_right;

    if (g == 0) begin : g_first
      assign le_left  = 1'b1;
      assign val_left = cmd.key;
    end else begin : g_inner_l
      assign le_left  = le[g-1];
      assign val_left = vals[g-1];
    end

    if (g == TABLE_DEPTH - 1) begin : g_last
      assign le_right  = 1'b0;
      assign val_right = vals[g];
    end else begin : g_inner_r
      assign le_right  = le[g+1];
      assign val_right = vals[g+1];
    end

    bfst_cell #(
      .Idx  (g),
      .CntW (CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .count_i     (count_q),
      .le_left_i   (le_left),
      .le_right_i  (le_right),
      .val_left_i  (val_left),
      .val_right_i (val_right),
      .le_o        (le[g]),
      .val_o       (vals[g]),
      .taken_o     (taken_pad[g])
    );
  end

  // pad the taken vector to whole groups
  for (genvar p = TABLE_DEPTH; p < NumGrp * GrpSize; p++) begin : g_pad
    assign taken_pad[p] = '0;
  end

  // first OR level, one group per register
  always_comb begin
    for (int unsigned k = 0; k < NumGrp; k++) begin
      grp_d[k] = '0;
      for (int unsigned j = 0; j < GrpSize; j++) begin
        grp_d[k] = grp_d[k] | taken_pad[k*GrpSize + j];
      end
    end
  end

  // second OR level over the group registers
  always_comb begin
    taken_all = '0;
    for (int unsigned k = 0; k < NumGrp; k++) begin
      taken_all = taken_all | grp_q[k];
    end
  end

  // next fill count and status
  always_comb begin
    count_d       = count_q;
    pend_status_d = ST_OK;
    if (req.opcode == OP_INSERT) begin
      if (full) begin
        pend_status_d = ST_FULL;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (le[0]) begin
        count_d = count_q - CntW'(1);
      end else begin
        pend_status_d = ST_NOFIT;
      end
    end
  end

  // fill count and pending flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        pend_q <= 1'b1;
      end else if (!out_valid_q || out_o.ready) begin
        pend_q <= 1'b0;
      end
    end
  end

  // pending payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_status_q <= pend_status_d;
      pend_occ_q    <= OccW'(count_d);
      for (int unsigned k = 0; k < NumGrp; k++) begin
        grp_q[k] <= grp_d[k];
      end
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pend_q && (!out_valid_q || out_o.ready)) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (pend_q && (!out_valid_q || out_o.ready)) begin
      out_q.status      <= pend_status_q;
      out_q.taken_value <= taken_all;
      out_q.occupancy   <= pend_occ_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // fill count stays within the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // an accepted item holds off the next one in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> pend_q && !in_i.ready)
    else $error("item accepted without pending result");

  // insert into a table with room grows the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins_en |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow the count");

  // failed items never report a taken value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.status != ST_OK)) |-> (out_q.taken_value == '0))
    else $error("taken value on failed item");

endmodule

`default_nettype wire

// File: hw/rtl/bfst_cell.sv
// bfst_cell: one entry of the sorted chain with its compare and shift logic
`default_nettype none

module bfst_cell #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 9
) (
  input  logic                   clk_i,
  input  bfst_pkg::cell_cmd_t    cmd_i,
  input  logic [CntW-1:0]        count_i,
  input  logic                   le_left_i,
  input  logic                   le_right_i,
  input  logic [bfst_pkg::ValW-1:0] val_left_i,
  input  logic [bfst_pkg::ValW-1:0] val_right_i,
  output logic                   le_o,
  output logic [bfst_pkg::ValW-1:0] val_o,
  output logic [bfst_pkg::ValW-1:0] taken_o
);
  import bfst_pkg::*;

  logic [ValW-1:0] val_q, val_d;
  logic            load;
  logic            in_use;
  logic            in_reach;
  logic            sel;

  // position relative to the fill level
  assign in_use   = CntW'(Idx) <  count_i;
  assign in_reach = CntW'(Idx) <= count_i;

  // stored value not above the key, prefix-shaped along the chain
  assign le_o  = in_use && (val_q <= cmd_i.key);
  assign val_o = val_q;

  // last qualifying cell holds the best fit, reported only for a take
  assign sel     = le_o && !le_right_i;
  assign taken_o = (sel && cmd_i.take_en) ? val_q : '0;

  // insert opens a gap at the boundary, take closes the gap at the best fit
  always_comb begin
    val_d = val_q;
    load  = 1'b0;
    if (cmd_i.ins_en && in_reach) begin
      if (!le_left_i) begin
        val_d = val_left_i;
        load  = 1'b1;
      end else if (!le_o) begin
        val_d = cmd_i.key;
        load  = 1'b1;
      end
    end else if (cmd_i.take_en && !le_right_i) begin
      val_d = val_right_i;
      load  = 1'b1;
    end
  end

  // entry storage, undefined until written
  always_ff @(posedge clk_i) begin
    if (load) begin
      val_q <= val_d;
    end
  end

endmodule

`default_nettype wire

// File: tb/bfst_checker.sv
// bfst_checker: tracks the sorted table, predicts each response and compares it
module bfst_checker #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic           req_ready_i,
  input  bfst_pkg::req_t req_i,
  input  logic           rsp_valid_i,
  input  logic           rsp_ready_i,
  input  bfst_pkg::rsp_t rsp_i,
  output int unsigned    fail_cnt_o,
  output int unsigned    outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bfst_pkg::*;

  // stored values in ascending order, duplicates kept in arrival order
  logic [ValW-1:0] stored_vals_q[$];
  // responses still owed by the table, oldest first
  rsp_t            owed_rsp_q[$];
  int unsigned     error_cnt = 0;

  assign fail_cnt_o = error_cnt;

  task automatic report_mismatch(input string what, input logic [ValW-1:0] got,
                                 input logic [ValW-1:0] want);
    $display("%0t ns: %s: got %0h, want %0h", $realtime, what, got, want);
    error_cnt++;
  endtask

  // apply one request to the tracked table and build its response
  function automatic rsp_t apply_request(input req_t req);
    rsp_t rsp;
    int   n_not_above;
    rsp.status      = ST_OK;
    rsp.taken_value = '0;
    n_not_above     = 0;
    while (n_not_above < stored_vals_q.size() &&
           stored_vals_q[n_not_above] <= req.value) begin
      n_not_above++;
    end
    if (req.opcode == OP_INSERT) begin
      if (stored_vals_q.size() >= TABLE_DEPTH) begin
        rsp.status = ST_FULL;
      end else begin
        stored_vals_q.insert(n_not_above, req.value);
      end
    end else if (n_not_above == 0) begin
      rsp.status = ST_NOFIT;
    end else begin
      rsp.taken_value = stored_vals_q[n_not_above-1];
      stored_vals_q.delete(n_not_above-1);
    end
    rsp.occupancy = OccW'(stored_vals_q.size());
    return rsp;
  endfunction

  // watch both channels at each rising edge
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (req_valid_i && req_ready_i) begin
        owed_rsp_q.push_back(apply_request(req_i));
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (owed_rsp_q.size() == 0) begin
          report_mismatch("response with nothing owed", rsp_i.taken_value, '0);
        end else begin
          want = owed_rsp_q.pop_front();
          if (rsp_i.status !== want.status) begin
            report_mismatch("status", ValW'(rsp_i.status), ValW'(want.status));
          end
          if (rsp_i.taken_value !== want.taken_value) begin
            report_mismatch("taken_value", rsp_i.taken_value, want.taken_value);
          end
          if (rsp_i.occupancy !== want.occupancy) begin
            report_mismatch("occupancy", ValW'(rsp_i.occupancy), ValW'(want.occupancy));
          end
        end
      end
      outstanding_o <= owed_rsp_q.size();
    end
  end

endmodule

// File: tb/tb_top.sv
// tb_top: clock, reset, request traffic and verdict for the best-fit sorted table
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bfst_pkg::*;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TailCycles = 10;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_cnt;
  int unsigned outstanding;

  // traffic shaping: idle_pct shared by sender and receiver, hold_req for the receiver
  int unsigned idle_pct;
  logic        hold_req;

  // recently inserted values, reused as duplicates and exact-match keys
  logic [ValW-1:0] recent_vals[16];
  int unsigned     recent_idx;

  bfst_stream_if #(.item_t(req_t)) req_if ();
  bfst_stream_if #(.item_t(rsp_t)) rsp_if ();

  best_fit_sorted_table #(
    .TABLE_DEPTH(TableDepth)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  bfst_checker #(
    .TABLE_DEPTH(TableDepth)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_if.valid),
    .req_ready_i  (req_if.ready),
    .req_i        (req_if.data),
    .rsp_valid_i  (rsp_if.valid),
    .rsp_ready_i  (rsp_if.ready),
    .rsp_i        (rsp_if.data),
    .fail_cnt_o   (fail_cnt),
    .outstanding_o(outstanding)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // reset, once
  initial begin
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // response side: random back-pressure and one long hold-off on request
  initial begin
    int unsigned gap;
    bit          hold_done;
    rsp_if.ready = 1'b0;
    hold_done    = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        rsp_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        gap = $urandom_range(1, 18);
        rsp_if.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // offer one request, return after the accepting edge
  task automatic send_req(input opcode_e op, input logic [ValW-1:0] val);
    int unsigned gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 18);
      @(negedge clk_i);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_if.valid <= 1'b1;
    req_if.data  <= '{opcode: op, value: val};
    if (op == OP_INSERT) begin
      recent_vals[recent_idx] = val;
      recent_idx = (recent_idx + 1) % 16;
    end
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // stop offering and wait until every response has come back
  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // value mix: extremes, small clustered values, repeats and full random
  function automatic logic [ValW-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return '0;
      1: return '1;
      2, 3: return ValW'($urandom_range(0, 63));
      4, 5: return recent_vals[$urandom_range(0, 15)];
      default: return $urandom();
    endcase
  endfunction

  task automatic run_phase(input int unsigned n_items, input int unsigned insert_pct,
                           input int unsigned gap_pct);
    opcode_e op;
    idle_pct = gap_pct;
    repeat (n_items) begin
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_TAKE;
      send_req(op, pick_value());
    end
  endtask

  // request traffic and verdict
  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    idle_pct     = 0;
    hold_req     = 1'b0;
    recent_idx   = 0;
    foreach (recent_vals[i]) recent_vals[i] = '0;
    wait (rst_ni);

    // takes on an empty table, extremes, duplicates, exact and near fits
    send_req(OP_TAKE,   32'h0000_0000);
    send_req(OP_TAKE,   32'hFFFF_FFFF);
    send_req(OP_INSERT, 32'h0000_0000);
    send_req(OP_INSERT, 32'hFFFF_FFFF);
    send_req(OP_INSERT, 32'h0000_0005);
    send_req(OP_INSERT, 32'h0000_0005);
    send_req(OP_INSERT, 32'h0000_0007);
    send_req(OP_TAKE,   32'h0000_0006);
    send_req(OP_TAKE,   32'h0000_0005);
    send_req(OP_TAKE,   32'h0000_0004);
    send_req(OP_TAKE,   32'h0000_0000);
    send_req(OP_TAKE,   32'hFFFF_FFFE);
    send_req(OP_TAKE,   32'hFFFF_FFFF);
    send_req(OP_INSERT, 32'h8000_0000);
    send_req(OP_INSERT, 32'h7FFF_FFFF);
    send_req(OP_INSERT, 32'hAAAA_5555);
    send_req(OP_INSERT, 32'h5555_AAAA);
    send_req(OP_TAKE,   32'h8000_0000);
    send_req(OP_TAKE,   32'h7FFF_FFFE);
    send_req(OP_TAKE,   32'hFFFF_FFFF);
    send_req(OP_TAKE,   32'h7FFF_FFFF);
    wait_drained();

    // fill past capacity, with a long response hold-off in the middle
    run_phase(40, 96, 25);
    hold_req = 1'b1;
    run_phase(40, 96, 0);
    run_phase(230, 96, 25);
    wait_drained();

    // balanced traffic, then drain toward empty
    run_phase(100, 50, 25);
    run_phase(280, 8, 25);
    wait_drained();

    // last stretch without any idling
    run_phase(50, 50, 0);
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("best_fit_sorted_table: match");
    end else begin
      $display("best_fit_sorted_table: mismatch");
    end
    $finish;
  end

  // watchdog on cycles with no accepted item on either channel
  initial begin
    int unsigned stall_cnt;
    stall_cnt = 0;
    wait (rst_ni);
    while (stall_cnt < StallLimit) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        stall_cnt = 0;
      end else begin
        stall_cnt++;
      end
    end
    $display("best_fit_sorted_table: mismatch");
    $finish;
  end

endmodule
